/* rtl/mltpt_pkg.sv */
// Package for the multi-lane tag presence tracker.
// Holds the per-lane state type, event codes, register indexes and id sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mltpt_pkg;

	localparam int MAX_ID_BYTES = 10;
	localparam int ID_LOW_W     = 64;
	localparam int ID_HIGH_W    = 16;
	localparam int LEN_W        = 4;
	localparam int MISS_W       = 8;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_IDX_W    = 1;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_ARRIVED = 2'd1;
	localparam logic [1:0] EV_REMOVED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LANE_READY_MASK  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REMOVE_THRESHOLD = 1'd1;

	typedef struct packed {
		logic                 present;
		logic [ID_LOW_W-1:0]  id_low;
		logic [ID_HIGH_W-1:0] id_high;
		logic [LEN_W-1:0]     length;
		logic [MISS_W-1:0]    miss;
	} lane_state_t;

	typedef struct packed {
		logic                 ready;
		logic                 found;
		logic [LEN_W-1:0]     length;
		logic [ID_LOW_W-1:0]  id_low;
		logic [ID_HIGH_W-1:0] id_high;
		logic [MISS_W-1:0]    threshold;
	} poll_t;

endpackage

`default_nettype wire

/* rtl/mltpt_lane_eval.sv */
// Next-state and event logic for the lane under the pointer.
// Depends on mltpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mltpt_lane_eval
	import mltpt_pkg::*;
(
	input  poll_t       poll,
	input  lane_state_t cur,
	output lane_state_t nxt,
	output logic [1:0]  event_code
);

	logic [LEN_W-1:0]     len_sat;
	logic [ID_LOW_W-1:0]  lo_m;
	logic [ID_HIGH_W-1:0] hi_m;
	logic [MISS_W-1:0]    miss_inc;
	logic                 changed;

	always_comb begin
		len_sat = (poll.length > LEN_W'(MAX_ID_BYTES)) ? LEN_W'(MAX_ID_BYTES) : poll.length;
		// bytes past the length read as zero
		for (int b = 0; b < 8; b++) begin
			lo_m[8*b +: 8] = (len_sat > LEN_W'(b)) ? poll.id_low[8*b +: 8] : 8'd0;
		end
		for (int b = 0; b < 2; b++) begin
			hi_m[8*b +: 8] = (len_sat > LEN_W'(b + 8)) ? poll.id_high[8*b +: 8] : 8'd0;
		end
		miss_inc = cur.miss + MISS_W'(1);
		changed  = !cur.present || (cur.length != len_sat) ||
		           (cur.id_low != lo_m) || (cur.id_high != hi_m);

		nxt        = cur;
		event_code = EV_NONE;
		if (poll.ready) begin
			if (poll.found && (len_sat != '0)) begin
				nxt.miss = '0;
				if (changed) begin
					nxt.present = 1'b1;
					nxt.length  = len_sat;
					nxt.id_low  = lo_m;
					nxt.id_high = hi_m;
					event_code  = EV_ARRIVED;
				end
			end else if (cur.present) begin
				if (miss_inc >= poll.threshold) begin
					nxt        = '0;
					event_code = EV_REMOVED;
				end else begin
					nxt.miss = miss_inc;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/multi_lane_tag_presence_tracker.sv */
// Top level of the multi-lane tag presence tracker: input register, lane store,
// result register and configuration registers. Depends on mltpt_pkg, mltpt_lane_eval.
//
// channel | dir | transfer when           | contents
// s_*     | in  | s_tvalid & s_tready     | one poll result
// m_*     | out | m_tvalid & m_tready     | lane, event, held identifier
// cfg_*   | in  | cfg_valid & cfg_ready   | register write (always ready)
//
// One item per cycle sustained while m_tready accepts results; each result passes through
// the input register and then the result register before it is offered on m_*.
// The lane update is a single read-compare-write of the lane registers at the pointer.
// arst_n clears pointer, lane stores, valid flags and loads register defaults.
// A stall on m_tready holds the result and, once the input register is full, s_tready.
`timescale 1ns / 1ps
`default_nettype none

module multi_lane_tag_presence_tracker
	import mltpt_pkg::*;
#(
	parameter int LANES = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [87:0]           s_tdata,   // id_length[3:0], id_bytes_low[67:4],
	                                         // id_bytes_high[83:68], zero pad
	input  wire  [0:0]            s_tuser,   // tag_found[0]
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [87:0]           m_tdata,   // held_id_low[63:0], held_id_high[79:64],
	                                         // held_length[83:80], zero pad
	output logic [3:0]            m_tuser,   // lane_number[1:0], event_code[3:2]
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [3:0]              lane_mask_q;
	logic [MISS_W-1:0]       threshold_q;
	logic [PTR_W-1:0]        ptr_q;
	lane_state_t             lane_q [LANES];

	logic                    valid_s1;
	logic                    found_s1;
	logic [LEN_W-1:0]        len_s1;
	logic [ID_LOW_W-1:0]     lo_s1;
	logic [ID_HIGH_W-1:0]    hi_s1;

	logic                    out_valid_q;
	logic [1:0]              lane_num_q;
	logic [1:0]              event_q;
	lane_state_t             held_q;

	logic                    adv;
	logic                    do_step;
	logic [4:0]              lane_ext;
	poll_t                   poll;
	lane_state_t             cur;
	lane_state_t             nxt;
	logic [1:0]              ev;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign do_step  = valid_s1 && adv;
	assign cfg_ready = 1'b1;

	assign lane_ext = 5'(ptr_q);
	assign cur      = lane_q[ptr_q];

	always_comb begin
		poll.ready     = (lane_ext < 5'd4) && lane_mask_q[lane_ext[1:0]];
		poll.found     = found_s1;
		poll.length    = len_s1;
		poll.id_low    = lo_s1;
		poll.id_high   = hi_s1;
		poll.threshold = threshold_q;
	end

	mltpt_lane_eval u_eval (
		.poll       (poll),
		.cur        (cur),
		.nxt        (nxt),
		.event_code (ev)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_mask_q <= 4'd15;
			threshold_q <= MISS_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LANE_READY_MASK:  lane_mask_q <= cfg_data[3:0];
				REG_REMOVE_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			found_s1 <= s_tuser[0];
			len_s1   <= s_tdata[3:0];
			lo_s1    <= s_tdata[67:4];
			hi_s1    <= s_tdata[83:68];
		end
	end

	// lane store and pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				lane_q[i] <= '0;
			end
		end else if (do_step) begin
			lane_q[ptr_q] <= nxt;
			ptr_q <= (ptr_q == PTR_W'(LANES - 1)) ? '0 : ptr_q + PTR_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			lane_num_q <= lane_ext[1:0];
			event_q    <= ev;
			held_q     <= nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, held_q.length, held_q.id_high, held_q.id_low};
	assign m_tuser  = {event_q, lane_num_q};

endmodule

`default_nettype wire

/* rtl/mltpt_checker.sv */
// Port-level checks for the multi-lane tag presence tracker, bound to the top level.
// Depends on mltpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mltpt_checker
	import mltpt_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [87:0] m_tdata,
	input wire [3:0]  m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[3:2] == EV_NONE || m_tuser[3:2] == EV_ARRIVED ||
		              m_tuser[3:2] == EV_REMOVED))
		else $error("bad event code");

	// a removal leaves the lane store cleared
	a_removed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:2] == EV_REMOVED |-> m_tdata[83:0] == 84'd0)
		else $error("removal left identifier data");

	a_arrived_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:2] == EV_ARRIVED |->
		m_tdata[83:80] != 4'd0 && m_tdata[83:80] <= 4'(MAX_ID_BYTES))
		else $error("arrival with bad length");

endmodule

bind multi_lane_tag_presence_tracker mltpt_checker u_mltpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for multi_lane_tag_presence_tracker: directed table, then
// random poll traffic per lane, checked against a behavioral lane tracker or the table's typed rows.
// Depends on mltpt_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
	import mltpt_pkg::*;

	localparam int LANES          = 4;
	localparam int CLK_HALF       = 6;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int N_DIRECTED     = 21;
	localparam int N_PHASES       = 9;
	localparam bit [63:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam bit [63:0] ID_A    = 64'hFFEE_DDCC_BBAA_9988;
	localparam bit [63:0] ID_B    = 64'h0123_4567_89AB_CDEF;

	typedef struct packed {
		bit [1:0]  lane;
		bit [1:0]  ev;
		bit [63:0] lo;
		bit [15:0] hi;
		bit [3:0]  len;
	} tag_report_t;

	typedef struct packed {
		bit        typed;
		bit        found;
		bit [3:0]  len;
		bit [63:0] lo;
		bit [15:0] hi;
		bit [1:0]  x_ev;
		bit [63:0] x_lo;
		bit [15:0] x_hi;
		bit [3:0]  x_len;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [87:0]           s_tdata;   // id_length[3:0], id_bytes_low[67:4],
	                                  // id_bytes_high[83:68], zero pad
	logic [0:0]            s_tuser;   // tag_found[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [87:0]           m_tdata;   // held_id_low[63:0], held_id_high[79:64],
	                                  // held_length[83:80], zero pad
	logic [3:0]            m_tuser;   // lane_number[1:0], event_code[3:2]
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	multi_lane_tag_presence_tracker #(.LANES(LANES)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// behavioral copy of the tracker state and registers
	bit [3:0]    ready_mask   = 4'hF;
	bit [7:0]    remove_after = 8'd3;
	int          next_lane    = 0;
	bit          lane_present [LANES];
	bit [63:0]   lane_id_lo   [LANES];
	bit [15:0]   lane_id_hi   [LANES];
	bit [3:0]    lane_len     [LANES];
	bit [7:0]    lane_misses  [LANES];

	tag_report_t pending_reports[$];
	int          fail_count  = 0;
	int          quiet_cycles = 0;
	bit          rx_hold_req = 1'b0;
	dir_row_t    directed_rows [N_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic bit [3:0] clip_len(bit [3:0] len);
		return (len > MAX_ID_BYTES) ? 4'(MAX_ID_BYTES) : len;
	endfunction

	function automatic bit [63:0] id_low_bytes_mask(bit [3:0] len);
		if (len >= 8)
			return ONES;
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	function automatic bit [15:0] id_high_bytes_mask(bit [3:0] len);
		if (len <= 8)
			return 16'h0000;
		if (len == 9)
			return 16'h00FF;
		return 16'hFFFF;
	endfunction

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// one poll result applied to the lane under the pointer
	task automatic track_poll(input bit found, input bit [3:0] len_in,
		input bit [63:0] lo_in, input bit [15:0] hi_in, output tag_report_t rpt);
		int        lane;
		bit [3:0]  len;
		bit [63:0] lo;
		bit [15:0] hi;
		bit [7:0]  misses;
		lane = next_lane;
		len = clip_len(len_in);
		rpt.ev = EV_NONE;
		if (ready_mask[lane]) begin
			if (found && len != 0) begin
				lo = lo_in & id_low_bytes_mask(len);
				hi = hi_in & id_high_bytes_mask(len);
				lane_misses[lane] = 8'd0;
				if (!lane_present[lane] || lane_len[lane] != len ||
					lane_id_lo[lane] != lo || lane_id_hi[lane] != hi) begin
					lane_present[lane] = 1'b1;
					lane_len[lane] = len;
					lane_id_lo[lane] = lo;
					lane_id_hi[lane] = hi;
					rpt.ev = EV_ARRIVED;
				end
			end else if (lane_present[lane]) begin
				misses = lane_misses[lane] + 8'd1;
				if (misses >= remove_after) begin
					lane_present[lane] = 1'b0;
					lane_misses[lane] = 8'd0;
					lane_len[lane] = 4'd0;
					lane_id_lo[lane] = 64'd0;
					lane_id_hi[lane] = 16'd0;
					rpt.ev = EV_REMOVED;
				end else begin
					lane_misses[lane] = misses;
				end
			end
		end
		rpt.lane = lane[1:0];
		rpt.lo = lane_id_lo[lane];
		rpt.hi = lane_id_hi[lane];
		rpt.len = lane_len[lane];
		next_lane = (lane + 1) % LANES;
	endtask

	// entered at a falling edge, returns at the falling edge after the transfer
	task automatic send_poll(input bit found, input bit [3:0] len, input bit [63:0] lo,
		input bit [15:0] hi, input int gap, input bit use_typed, input tag_report_t typed);
		tag_report_t rpt;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, hi, lo, len};
		s_tuser <= found;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_poll(found, len, lo, hi, rpt);
		pending_reports.push_back(use_typed ? typed : rpt);
		@(negedge clk);
	endtask

	task automatic program_regs(input bit [3:0] mask, input bit [7:0] thr);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LANE_READY_MASK;
		cfg_data <= {4'd0, mask};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ready_mask = mask;
		@(negedge clk);
		cfg_index <= REG_REMOVE_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		remove_after = thr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and wait for the pipeline to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly repeats and small edits of the lane's current tag so that
	// unchanged reads, changes and miss runs up to removal all occur
	task automatic run_poll_traffic(input int count, input int miss_pct, input bit hold);
		tag_report_t none;
		int          i;
		int          lane;
		int          pick;
		int          b;
		int          gap;
		bit          found;
		bit [3:0]    len;
		bit [63:0]   lo;
		bit [15:0]   hi;
		bit [7:0]    flip;
		none = '0;
		for (i = 0; i < count; i++) begin
			if (hold && i == 20)
				rx_hold_req = 1'b1;
			lane = next_lane;
			lo = {$urandom, $urandom};
			hi = 16'($urandom);
			pick = $urandom_range(99);
			if ($urandom_range(99) < miss_pct) begin
				found = ($urandom_range(3) == 0);
				len = found ? 4'd0 : 4'($urandom_range(15));
			end else begin
				found = 1'b1;
				if (lane_present[lane] && pick < 75) begin
					len = lane_len[lane];
					if (len == MAX_ID_BYTES && $urandom_range(1) == 1)
						len = 4'($urandom_range(15, MAX_ID_BYTES));
					lo = (lo & ~id_low_bytes_mask(len)) | lane_id_lo[lane];
					hi = (hi & ~id_high_bytes_mask(len)) | lane_id_hi[lane];
					if (pick >= 55) begin
						if ($urandom_range(3) == 0) begin
							len = 4'($urandom_range(MAX_ID_BYTES, 1));
						end else begin
							b = $urandom_range(clip_len(len) - 1, 0);
							flip = 8'd1 << $urandom_range(7);
							if (b < 8)
								lo ^= {56'd0, flip} << (8 * b);
							else
								hi ^= {8'd0, flip} << (8 * (b - 8));
						end
					end
				end else begin
					len = 4'($urandom_range(15, 1));
				end
			end
			gap = (rx_hold_req || ((i / 80) % 3 == 2)) ? 0 : pick_gap();
			send_poll(found, len, lo, hi, gap, 1'b0, none);
		end
	endtask

	initial begin : receiver
		int rx_gap_left;
		int rx_cycle;
		rx_gap_left = 0;
		rx_cycle = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (rx_gap_left > 0) begin
				m_tready <= 1'b0;
				rx_gap_left--;
			end else begin
				m_tready <= 1'b1;
				if ((rx_cycle / 250) % 3 != 0)
					rx_gap_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		tag_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected result lane %0d ev %0d",
					m_tuser[1:0], m_tuser[3:2]));
			end else begin
				want = pending_reports.pop_front();
				if (m_tuser[1:0] !== want.lane || m_tuser[3:2] !== want.ev ||
					m_tdata[63:0] !== want.lo || m_tdata[79:64] !== want.hi ||
					m_tdata[83:80] !== want.len) begin
					note_failure($sformatf(
						"exp lane %0d ev %0d id %h_%h len %0d, got lane %0d ev %0d id %h_%h len %0d",
						want.lane, want.ev, want.hi, want.lo, want.len,
						m_tuser[1:0], m_tuser[3:2], m_tdata[79:64], m_tdata[63:0],
						m_tdata[83:80]));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		bit [3:0]    phase_mask [N_PHASES] = '{4'hF, 4'h0, 4'hF, 4'h5, 4'hA, 4'h1, 4'h1, 4'hF, 4'h6};
		bit [7:0]    phase_thr  [N_PHASES] = '{8'd1, 8'd0, 8'd0, 8'd2, 8'd4, 8'd255, 8'd128,
			8'd3, 8'd5};
		int          phase_len  [N_PHASES] = '{100, 40, 100, 100, 100, 4, 520, 120, 95};
		int          phase_miss [N_PHASES] = '{30, 30, 30, 35, 40, 0, 100, 30, 30};
		bit          phase_hold [N_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		tag_report_t typed;
		int          i;
		int          p;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// after reset: all lanes ready, threshold three
		directed_rows = '{
			'{1'b1, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b1, 1'b1, 4'd15, ONES,  16'hFFFF,   EV_ARRIVED, ONES, 16'hFFFF, 4'd10},
			'{1'b1, 1'b1, 4'd0,  ID_B,  16'h1234,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b1, 1'b1, 4'd3,  ID_A,  16'hBEEF,   EV_ARRIVED, 64'hAA9988, 16'd0, 4'd3},
			'{1'b0, 1'b1, 4'd8,  ID_B,  16'h5555,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd12, ONES,  16'hFFFF,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd5,  ID_A,  16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd3,  64'h1234_5678_90AA_9988, 16'd0,
				EV_NONE, 64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd9,  ID_B,  16'h5555,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd10, ONES,  16'hFFFF,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd1,  64'hFF, 16'd0,     EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd0,  ID_A,  16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b0, 4'd0,  64'd0, 16'd0,      EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b1, 1'b0, 4'd0,  64'd0, 16'd0,      EV_REMOVED, 64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd1,  64'h12FF, 16'd0,   EV_NONE,    64'd0, 16'd0, 4'd0},
			'{1'b1, 1'b0, 4'd0,  64'd0, 16'd0,      EV_REMOVED, 64'd0, 16'd0, 4'd0},
			'{1'b0, 1'b1, 4'd9,  ID_B,  16'h55AA,   EV_NONE,    64'd0, 16'd0, 4'd0}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			typed.lane = 2'(i % LANES);
			typed.ev = directed_rows[i].x_ev;
			typed.lo = directed_rows[i].x_lo;
			typed.hi = directed_rows[i].x_hi;
			typed.len = directed_rows[i].x_len;
			send_poll(directed_rows[i].found, directed_rows[i].len, directed_rows[i].lo,
				directed_rows[i].hi, (i < 8) ? 0 : pick_gap(), directed_rows[i].typed, typed);
		end

		for (p = 0; p < N_PHASES; p++) begin
			settle();
			program_regs(phase_mask[p], phase_thr[p]);
			run_poll_traffic(phase_len[p], phase_miss[p], phase_hold[p]);
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
